FILE: hdl/albr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// albr_pkg: shared types and constants of the ambient light brightness ramp
// Holds the register map codes, the sequencer state type and fixed widths.
// ----------------------------------------------------------------------------
package albr_pkg;

  // Fixed field widths
  localparam int BRIGHT_W   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  // Divisor width: holds twice the largest window length
  localparam int DVS_W      = 11;

  // Mapping starts this far above the minimum brightness
  localparam int BRIGHT_BASE_OFS = 20;
  // User offset that leaves the target unshifted
  localparam int OFFSET_NEUTRAL  = 100;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RESET_DELTA      = 3'd0,
    CFG_WINDOW_LEN       = 3'd1,
    CFG_CHANGE_THRESHOLD = 3'd2,
    CFG_SENSOR_MIN       = 3'd3,
    CFG_SENSOR_MAX       = 3'd4,
    CFG_BRIGHT_MIN       = 3'd5,
    CFG_BRIGHT_MAX       = 3'd6,
    CFG_BRIGHT_OFFSET    = 3'd7
  } albr_cfg_e;

  // Sequencer states, one-hot
  typedef enum logic [9:0] {
    ST_IDLE     = 10'b00_0000_0001,
    ST_ACCUM    = 10'b00_0000_0010,
    ST_AVG_DIV  = 10'b00_0000_0100,
    ST_AVG_END  = 10'b00_0000_1000,
    ST_MAP_MUL  = 10'b00_0001_0000,
    ST_MAP_LOAD = 10'b00_0010_0000,
    ST_MAP_DIV  = 10'b00_0100_0000,
    ST_MAP_END  = 10'b00_1000_0000,
    ST_TARGET   = 10'b01_0000_0000,
    ST_EMIT     = 10'b10_0000_0000
  } albr_state_e;

endpackage

FILE: hdl/albr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// albr_if: valid/ready channels of the ambient light brightness ramp
// Input channel carries one sensor tick, output channel one brightness word.
// ----------------------------------------------------------------------------
interface albr_in_if
  import albr_pkg::*;
#(
  parameter int SAMPLE_BITS = 7
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   active;
  logic [BRIGHT_W-1:0]    current_brightness;

  modport source (output valid, sample, active, current_brightness, input ready);
  modport sink   (input valid, sample, active, current_brightness, output ready);
endinterface

interface albr_out_if
  import albr_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [BRIGHT_W-1:0] brightness;
  logic                brightness_changed;
  logic                save_request;

  modport source (output valid, brightness, brightness_changed, save_request, input ready);
  modport sink   (input valid, brightness, brightness_changed, save_request, output ready);
endinterface

FILE: hdl/ambient_light_brightness_ramp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ambient_light_brightness_ramp_core: ambient light driven brightness ramp
// Averages sensor ticks over a window, maps the level to a brightness target
// and ramps the panel brightness toward it one step per tick.
// ----------------------------------------------------------------------------
// One word in gives one word out. An inactive tick goes straight to the emit
// state, an active tick that does not close a window is accumulated first, one
// that closes a window without a level change also runs the average division,
// and one that maps a new level runs the mapping division too when the sensor
// range is positive. Both use a single restoring divider of DW bits, where DW =
// max(SAMPLE_BITS+WINDOW_BITS+2, 20), one quotient bit per cycle, that first
// forms the rounded window average and then the rounded linear mapping. The
// input is not ready while a tick is in work; a finished word waits in the
// output register and the next tick may be accepted meanwhile.
module ambient_light_brightness_ramp_core
  import albr_pkg::*;
#(
  parameter int SAMPLE_BITS = 7,
  parameter int WINDOW_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  albr_in_if.sink               in_i,
  albr_out_if.source            out_o
);

  localparam int SUM_W = SAMPLE_BITS + WINDOW_BITS;
  localparam int DW    = (SUM_W + 2 > 20) ? SUM_W + 2 : 20;
  localparam int DCW   = $clog2(DW);
  localparam int AW    = (SAMPLE_BITS > 7) ? SAMPLE_BITS : 7;
  localparam logic [DCW-1:0] DIV_LAST = DCW'(DW - 1);

  // Saturate a signed value to the brightness range
  function automatic logic [7:0] sat8(logic signed [19:0] v);
    logic [7:0] r;
    if (v < 0) begin
      r = 8'd0;
    end else if (v > 20'sd255) begin
      r = 8'd255;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  // Configuration registers
  logic [6:0] reset_delta_q, reset_delta_d;
  logic [9:0] window_len_q, window_len_d;
  logic [7:0] thr_q, thr_d;
  logic [6:0] smin_q, smin_d;
  logic [6:0] smax_q, smax_d;
  logic [7:0] bmin_q, bmin_d;
  logic [7:0] bmax_q, bmax_d;
  logic [7:0] boffs_q, boffs_d;

  // Captured tick
  logic [SAMPLE_BITS-1:0] smp_q, smp_d;
  logic                   act_q, act_d;
  logic [7:0]             cur_q, cur_d;

  // Filter and ramp state
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [9:0]             cnt_q, cnt_d;
  logic [SAMPLE_BITS-1:0] ref_q, ref_d;
  logic [7:0]             level_q, level_d;
  logic [7:0]             ramp_now_q, ramp_now_d;
  logic [7:0]             ramp_tgt_q, ramp_tgt_d;
  logic                   save_pend_q, save_pend_d;

  // Mapping datapath
  logic signed [18:0] mul_q, mul_d;
  logic               map_neg_q, map_neg_d;
  logic [7:0]         mapped_q, mapped_d;

  // Shared divider
  logic [DVS_W-1:0] div_rem_q, div_rem_d;
  logic [DW-1:0]    div_quo_q, div_quo_d;
  logic [DVS_W-1:0] div_dvs_q, div_dvs_d;
  logic [DCW-1:0]   div_cnt_q, div_cnt_d;

  // Output register
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_bright_q, out_bright_d;
  logic       out_chg_q, out_chg_d;
  logic       out_save_q, out_save_d;

  albr_state_e state_q, state_d;

  // Divider step terms
  logic [DVS_W:0]   div_shift;
  logic [DVS_W:0]   div_diff;
  logic             div_ge;

  // Datapath temporaries
  logic [AW-1:0]          smp_ext, ref_ext, smp_dist;
  logic                   restart;
  logic [SUM_W-1:0]       sum_base, sum_new;
  logic [10:0]            cnt_inc;
  logic [9:0]             div_len;
  logic [7:0]             avg8;
  logic [7:0]             avg_dist;
  logic signed [7:0]      den;
  logic [8:0]             base;
  logic signed [9:0]      span;
  logic signed [8:0]      lvl_ofs;
  logic signed [19:0]     map_num;
  logic [19:0]            map_mag;
  logic signed [19:0]     map_q;
  logic [7:0]             tgt_dist;
  logic [8:0]             tgt_sum, tgt_sub;
  logic                   out_free;

  assign div_shift = {div_rem_q, div_quo_q[DW-1]};
  assign div_diff  = div_shift - {1'b0, div_dvs_q};
  assign div_ge    = div_shift >= {1'b0, div_dvs_q};

  assign out_free  = !out_valid_q || out_o.ready;
  assign base      = 9'({1'b0, bmin_q} + 9'(BRIGHT_BASE_OFS));
  assign den       = $signed({1'b0, smax_q}) - $signed({1'b0, smin_q});

  // Next-state logic of the sequencer and datapath
  always_comb begin
    reset_delta_d = reset_delta_q;
    window_len_d  = window_len_q;
    thr_d         = thr_q;
    smin_d        = smin_q;
    smax_d        = smax_q;
    bmin_d        = bmin_q;
    bmax_d        = bmax_q;
    boffs_d       = boffs_q;
    smp_d         = smp_q;
    act_d         = act_q;
    cur_d         = cur_q;
    sum_d         = sum_q;
    cnt_d         = cnt_q;
    ref_d         = ref_q;
    level_d       = level_q;
    ramp_now_d    = ramp_now_q;
    ramp_tgt_d    = ramp_tgt_q;
    save_pend_d   = save_pend_q;
    mul_d         = mul_q;
    map_neg_d     = map_neg_q;
    mapped_d      = mapped_q;
    div_rem_d     = div_rem_q;
    div_quo_d     = div_quo_q;
    div_dvs_d     = div_dvs_q;
    div_cnt_d     = div_cnt_q;
    out_valid_d   = out_valid_q && !out_o.ready;
    out_bright_d  = out_bright_q;
    out_chg_d     = out_chg_q;
    out_save_d    = out_save_q;
    state_d       = state_q;

    smp_ext  = AW'(smp_q);
    ref_ext  = AW'(ref_q);
    smp_dist = (smp_ext >= ref_ext) ? smp_ext - ref_ext : ref_ext - smp_ext;
    restart  = smp_dist > AW'(reset_delta_q);
    sum_base = restart ? '0 : sum_q;
    sum_new  = sum_base + SUM_W'(smp_q);
    cnt_inc  = (restart ? 11'd0 : {1'b0, cnt_q}) + 11'd1;
    div_len  = (window_len_q == 10'd0) ? 10'd1 : window_len_q;

    avg8     = (div_quo_q > DW'(255)) ? 8'd255 : div_quo_q[7:0];
    avg_dist = (avg8 >= level_q) ? avg8 - level_q : level_q - avg8;

    span     = $signed({2'b00, bmax_q}) - $signed({1'b0, base});
    lvl_ofs  = $signed({1'b0, level_q - {1'b0, smin_q}});
    map_num  = $signed({mul_q, 1'b0}) + 20'(den);
    map_mag  = map_num[19] ? 20'(-map_num) : map_num;
    map_q    = $signed({2'b00, div_quo_q[17:0]});
    if (map_neg_q) begin
      map_q = -(map_q + ((div_rem_q != '0) ? 20'sd1 : 20'sd0));
    end

    tgt_dist = (ramp_now_q >= mapped_q) ? ramp_now_q - mapped_q : mapped_q - ramp_now_q;
    tgt_sum  = {1'b0, mapped_q} + {1'b0, boffs_q};
    tgt_sub  = (tgt_sum < 9'(OFFSET_NEUTRAL)) ? 9'd0 : tgt_sum - 9'(OFFSET_NEUTRAL);

    // Register writes
    if (cfg_we_i) begin
      unique case (albr_cfg_e'(cfg_idx_i))
        CFG_RESET_DELTA:      reset_delta_d = cfg_data_i[6:0];
        CFG_WINDOW_LEN:       window_len_d  = cfg_data_i[9:0];
        CFG_CHANGE_THRESHOLD: thr_d         = cfg_data_i[7:0];
        CFG_SENSOR_MIN:       smin_d        = cfg_data_i[6:0];
        CFG_SENSOR_MAX:       smax_d        = cfg_data_i[6:0];
        CFG_BRIGHT_MIN:       bmin_d        = cfg_data_i[7:0];
        CFG_BRIGHT_MAX:       bmax_d        = cfg_data_i[7:0];
        CFG_BRIGHT_OFFSET:    boffs_d       = cfg_data_i[7:0];
        default: ;
      endcase
    end

    unique case (state_q) inside
      // Take a tick
      ST_IDLE: begin
        if (in_i.valid) begin
          smp_d   = in_i.sample;
          act_d   = in_i.active;
          cur_d   = in_i.current_brightness;
          state_d = in_i.active ? ST_ACCUM : ST_EMIT;
        end
      end
      // Accumulate; close the window and start the average division
      ST_ACCUM: begin
        if (restart) begin
          ref_d = smp_q;
        end
        if (cnt_inc > {1'b0, window_len_q}) begin
          sum_d     = '0;
          cnt_d     = '0;
          div_rem_d = '0;
          div_quo_d = DW'({sum_new, 1'b0}) + DW'(div_len);
          div_dvs_d = {div_len, 1'b0};
          div_cnt_d = '0;
          state_d   = ST_AVG_DIV;
        end else begin
          sum_d   = sum_new;
          cnt_d   = cnt_inc[9:0];
          state_d = ST_EMIT;
        end
      end
      // One quotient bit per cycle
      ST_AVG_DIV, ST_MAP_DIV: begin
        div_rem_d = div_ge ? div_diff[DVS_W-1:0] : div_shift[DVS_W-1:0];
        div_quo_d = {div_quo_q[DW-2:0], div_ge};
        div_cnt_d = div_cnt_q + 1'b1;
        if (div_cnt_q == DIV_LAST) begin
          state_d = (state_q == ST_AVG_DIV) ? ST_AVG_END : ST_MAP_END;
        end
      end
      // Compare the average to the level and clamp it
      ST_AVG_END: begin
        if (avg_dist > thr_q) begin
          if (avg8 > {1'b0, smax_q}) begin
            level_d = {1'b0, smax_q};
          end else if (avg8 < {1'b0, smin_q}) begin
            level_d = {1'b0, smin_q};
          end else begin
            level_d = avg8;
          end
          ramp_now_d = cur_q;
          state_d    = ST_MAP_MUL;
        end else begin
          state_d = ST_EMIT;
        end
      end
      // Scale the level offset by the brightness span
      ST_MAP_MUL: begin
        if (den > 0) begin
          mul_d   = 19'(span * lvl_ofs);
          state_d = ST_MAP_LOAD;
        end else begin
          mapped_d = sat8($signed({11'd0, base}));
          state_d  = ST_TARGET;
        end
      end
      // Load the magnitude of the rounded mapping into the divider
      ST_MAP_LOAD: begin
        map_neg_d = map_num[19];
        div_rem_d = '0;
        div_quo_d = DW'(map_mag);
        div_dvs_d = DVS_W'({den, 1'b0});
        div_cnt_d = '0;
        state_d   = ST_MAP_DIV;
      end
      // Restore the sign with floor rounding and add the base
      ST_MAP_END: begin
        mapped_d = sat8(map_q + $signed({11'd0, base}));
        state_d  = ST_TARGET;
      end
      // Set a new target if the mapping moved far enough
      ST_TARGET: begin
        if (tgt_dist > thr_q) begin
          if (tgt_sub > {1'b0, bmax_q}) begin
            ramp_tgt_d = bmax_q;
          end else if (tgt_sub < {1'b0, bmin_q}) begin
            ramp_tgt_d = bmin_q;
          end else begin
            ramp_tgt_d = tgt_sub[7:0];
          end
          save_pend_d = 1'b1;
        end else begin
          ramp_tgt_d = ramp_now_q;
        end
        state_d = ST_EMIT;
      end
      // Step the ramp and hand the word to the output register
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_bright_d = cur_q;
          out_chg_d    = 1'b0;
          out_save_d   = 1'b0;
          if (act_q) begin
            if (ramp_now_q > ramp_tgt_q) begin
              ramp_now_d   = ramp_now_q - 8'd1;
              out_bright_d = ramp_now_q - 8'd1;
              out_chg_d    = 1'b1;
            end else if (ramp_now_q < ramp_tgt_q) begin
              ramp_now_d   = ramp_now_q + 8'd1;
              out_bright_d = ramp_now_q + 8'd1;
              out_chg_d    = 1'b1;
            end else if (save_pend_q) begin
              save_pend_d = 1'b0;
              out_save_d  = 1'b1;
            end
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_delta_q <= 7'd4;
      window_len_q  <= 10'd16;
      thr_q         <= 8'd3;
      smin_q        <= 7'd0;
      smax_q        <= 7'd127;
      bmin_q        <= 8'd0;
      bmax_q        <= 8'd100;
      boffs_q       <= 8'd100;
      sum_q         <= '0;
      cnt_q         <= '0;
      ref_q         <= '0;
      level_q       <= '0;
      ramp_now_q    <= '0;
      ramp_tgt_q    <= '0;
      save_pend_q   <= 1'b0;
      div_cnt_q     <= '0;
      out_valid_q   <= 1'b0;
      state_q       <= ST_IDLE;
    end else begin
      reset_delta_q <= reset_delta_d;
      window_len_q  <= window_len_d;
      thr_q         <= thr_d;
      smin_q        <= smin_d;
      smax_q        <= smax_d;
      bmin_q        <= bmin_d;
      bmax_q        <= bmax_d;
      boffs_q       <= boffs_d;
      sum_q         <= sum_d;
      cnt_q         <= cnt_d;
      ref_q         <= ref_d;
      level_q       <= level_d;
      ramp_now_q    <= ramp_now_d;
      ramp_tgt_q    <= ramp_tgt_d;
      save_pend_q   <= save_pend_d;
      div_cnt_q     <= div_cnt_d;
      out_valid_q   <= out_valid_d;
      state_q       <= state_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    smp_q        <= smp_d;
    act_q        <= act_d;
    cur_q        <= cur_d;
    mul_q        <= mul_d;
    map_neg_q    <= map_neg_d;
    mapped_q     <= mapped_d;
    div_rem_q    <= div_rem_d;
    div_quo_q    <= div_quo_d;
    div_dvs_q    <= div_dvs_d;
    out_bright_q <= out_bright_d;
    out_chg_q    <= out_chg_d;
    out_save_q   <= out_save_d;
  end

  assign in_i.ready               = (state_q == ST_IDLE);
  assign out_o.valid              = out_valid_q;
  assign out_o.brightness         = out_bright_q;
  assign out_o.brightness_changed = out_chg_q;
  assign out_o.save_request       = out_save_q;

endmodule

FILE: hdl/albr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// albr_checker: port-level checks of the ambient light brightness ramp
// Watches the channels of the core and flags handshake and result slips.
// ----------------------------------------------------------------------------
module albr_checker
  import albr_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [BRIGHT_W-1:0] brightness_i,
  input logic                changed_i,
  input logic                save_i
);

  // Hold a stalled output word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(brightness_i)
      && $stable(changed_i) && $stable(save_i))
    else $error("albr: stalled output word changed");

  // A save is requested only on a tick without a ramp step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(changed_i && save_i))
    else $error("albr: save request together with a ramp step");

  // Drop ready while a word is in work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("albr: input ready right after accept");

  // A new output word never appears in the cycle after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_valid_i && in_ready_i))
    else $error("albr: output word too early");

endmodule

bind ambient_light_brightness_ramp_core albr_checker u_albr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .brightness_i (out_o.brightness),
  .changed_i    (out_o.brightness_changed),
  .save_i       (out_o.save_request)
);
